// ===== hdl/idp_pkg.sv =====
// Shared types and constants for the interrupt priority dispatcher.
// Used by every module of the block; depends on nothing else.
package idp_pkg;

    localparam int NUM_LINES_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int DATA_W  = 32;
    localparam int LINE_W  = 5;
    localparam int ADDR_W  = 4;

    localparam logic [LINE_W-1:0] TIMER_LINE_RESET = 5'd15;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_HANDLED = 2'd1;
    localparam logic [1:0] REG_TIMER   = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_HANDLER = 2'd1,
        ACT_SPUR    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_SERVE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] enable_mask;
        logic [DATA_W-1:0] handled_mask;
        logic [LINE_W-1:0] timer_line;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic serve;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_now;
    } status_t;

endpackage

// ===== hdl/interrupt_dispatch_priority.sv =====
// Top level of the interrupt priority dispatcher: configuration registers,
// controller and datapath. Depends on idp_pkg, idp_cfg, idp_ctrl and idp_dp.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_pending_lines
//  m_       out        m_valid/m_ready    served_line, action, line_count,
//                                         spurious_total, masked_lines, last
//  apb      in         psel/penable       paddr, pwdata, prdata
//
// An input beat is taken only while the block is idle, then one result leaves per
// cycle while the output is not stalled, one per served line (at most NUM_LINES)
// or a single one when nothing is pending; no new beat is taken until the last
// result of an item is produced. Reset is synchronous and clears all counters and
// the disabled mask.
// A stalled output holds the current result and pauses the serving step.
module interrupt_dispatch_priority #(
    parameter int NUM_LINES   = idp_pkg::NUM_LINES_DEF,
    parameter int COUNT_WIDTH = idp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [idp_pkg::ADDR_W-1:0] paddr,
    input  logic [idp_pkg::DATA_W-1:0] pwdata,
    output logic [idp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [idp_pkg::DATA_W-1:0] s_pending_lines,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [idp_pkg::LINE_W-1:0] m_served_line,
    output logic [1:0]                 m_action,
    output logic [idp_pkg::DATA_W-1:0] m_line_count,
    output logic [idp_pkg::DATA_W-1:0] m_spurious_total,
    output logic [idp_pkg::DATA_W-1:0] m_masked_lines,
    output logic                       m_last
);
    import idp_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    idp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    idp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    idp_dp #(
        .NUM_LINES   (NUM_LINES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .s_pending_lines  (s_pending_lines),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_served_line    (m_served_line),
        .m_action         (m_action),
        .m_line_count     (m_line_count),
        .m_spurious_total (m_spurious_total),
        .m_masked_lines   (m_masked_lines),
        .m_last           (m_last)
    );

endmodule

// ===== hdl/idp_cfg.sv =====
// Configuration register file with an APB-style slave port.
// Depends on idp_pkg for the register indexes and the cfg_t struct.
module idp_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [idp_pkg::ADDR_W-1:0] paddr,
    input  logic [idp_pkg::DATA_W-1:0] pwdata,
    output logic [idp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output idp_pkg::cfg_t              cfg
);
    import idp_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_mask  <= '0;
            cfg_reg.handled_mask <= '0;
            cfg_reg.timer_line   <= TIMER_LINE_RESET;
        end else if (wr_en) begin
            unique case (index)
                REG_ENABLE:  cfg_reg.enable_mask  <= pwdata;
                REG_HANDLED: cfg_reg.handled_mask <= pwdata;
                REG_TIMER:   cfg_reg.timer_line   <= pwdata[LINE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_ENABLE:  prdata = cfg_reg.enable_mask;
            REG_HANDLED: prdata = cfg_reg.handled_mask;
            REG_TIMER:   prdata = DATA_W'(cfg_reg.timer_line);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/idp_ctrl.sv =====
// Controller state machine: takes an input beat, then steps the datapath
// once per result. Depends on idp_pkg for state_t, cmd_t and status_t.
module idp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  idp_pkg::status_t status,
    output idp_pkg::cmd_t    cmd
);
    import idp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE: begin
                // A result is produced only when the output register can take it.
                if (status.out_free) begin
                    cmd.serve = 1'b1;
                    if (status.last_now) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/idp_dp.sv =====
// Datapath: pending mask, per-line service counters, spurious tally and
// the result output register. Depends on idp_pkg for types and action codes.
module idp_dp #(
    parameter int NUM_LINES   = idp_pkg::NUM_LINES_DEF,
    parameter int COUNT_WIDTH = idp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  idp_pkg::cfg_t              cfg,
    input  idp_pkg::cmd_t              cmd,
    output idp_pkg::status_t           status,
    input  logic [idp_pkg::DATA_W-1:0] s_pending_lines,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [idp_pkg::LINE_W-1:0] m_served_line,
    output logic [1:0]                 m_action,
    output logic [idp_pkg::DATA_W-1:0] m_line_count,
    output logic [idp_pkg::DATA_W-1:0] m_spurious_total,
    output logic [idp_pkg::DATA_W-1:0] m_masked_lines,
    output logic                       m_last
);
    import idp_pkg::*;

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int EXT_W = (COUNT_WIDTH >= DATA_W) ? COUNT_WIDTH : DATA_W;

    logic [NUM_LINES-1:0]   pend_reg, pend_next;
    logic                   first_reg;
    logic [COUNT_WIDTH-1:0] count_reg [NUM_LINES];
    logic [COUNT_WIDTH-1:0] spur_reg, spur_next;
    logic [NUM_LINES-1:0]   disabled_reg, disabled_next;

    logic                   m_valid_reg;
    logic [LINE_W-1:0]      m_line_reg;
    action_t                m_action_reg;
    logic [DATA_W-1:0]      m_count_reg;
    logic [DATA_W-1:0]      m_spur_reg;
    logic [DATA_W-1:0]      m_masked_reg;
    logic                   m_last_reg;

    logic [NUM_LINES-1:0]   in_pend;
    logic                   tick_ok;
    logic                   tick_hit;
    logic                   any_pend;
    logic [IDX_W-1:0]       hi_idx;
    logic [IDX_W-1:0]       sel;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic [COUNT_WIDTH-1:0] count_next;
    action_t                act;
    logic                   none_case;
    logic [EXT_W-1:0]       count_ext, spur_ext;

    assign in_pend = s_pending_lines[NUM_LINES-1:0] & cfg.enable_mask[NUM_LINES-1:0]
                     & ~disabled_reg;

    // The tick is only eligible on the first step of an item.
    assign tick_ok  = ({1'b0, cfg.timer_line} < (LINE_W + 1)'(NUM_LINES));
    assign tick_hit = first_reg && tick_ok && pend_reg[cfg.timer_line[IDX_W-1:0]];
    assign any_pend = |pend_reg;

    always_comb begin
        hi_idx = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (pend_reg[i]) begin
                hi_idx = IDX_W'(i);
            end
        end
    end

    assign none_case = !any_pend;
    assign sel       = tick_hit ? cfg.timer_line[IDX_W-1:0] : hi_idx;
    assign sel_count = count_reg[sel];

    always_comb begin
        spur_next     = spur_reg;
        disabled_next = disabled_reg;
        count_next    = sel_count;
        if (none_case) begin
            act = ACT_NONE;
        end else if (tick_hit) begin
            act        = ACT_TICK;
            count_next = sel_count + 1'b1;
        end else if (cfg.handled_mask[sel]) begin
            act        = ACT_HANDLER;
            count_next = sel_count + 1'b1;
        end else begin
            act           = ACT_SPUR;
            spur_next     = spur_reg + 1'b1;
            disabled_next = disabled_reg | (NUM_LINES'(1) << sel);
        end
    end

    assign pend_next       = pend_reg & ~(NUM_LINES'(1) << sel);
    assign status.last_now = none_case || (pend_next == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    assign count_ext = none_case ? '0 : EXT_W'(count_next);
    assign spur_ext  = EXT_W'(spur_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg    <= 1'b0;
            spur_reg     <= '0;
            disabled_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                first_reg <= 1'b1;
            end else if (cmd.serve) begin
                first_reg <= 1'b0;
            end
            if (cmd.serve) begin
                spur_reg     <= spur_next;
                disabled_reg <= disabled_next;
                if (!none_case) begin
                    count_reg[sel] <= count_next;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pend_reg <= in_pend;
        end else if (cmd.serve) begin
            pend_reg <= pend_next;
        end
        if (cmd.serve) begin
            m_line_reg   <= none_case ? '0 : LINE_W'(sel);
            m_action_reg <= act;
            m_count_reg  <= count_ext[DATA_W-1:0];
            m_spur_reg   <= spur_ext[DATA_W-1:0];
            m_masked_reg <= DATA_W'(disabled_next);
            m_last_reg   <= status.last_now;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_served_line    = m_line_reg;
    assign m_action         = m_action_reg;
    assign m_line_count     = m_count_reg;
    assign m_spurious_total = m_spur_reg;
    assign m_masked_lines   = m_masked_reg;
    assign m_last           = m_last_reg;

endmodule

// ===== tb/idp_checker.sv =====
// Scoreboard for the interrupt priority dispatcher: follows register writes and
// input beats, predicts every result beat and compares it field by field.
// Depends on idp_pkg for the action codes and register indexes.
module idp_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [idp_pkg::ADDR_W-1:0] paddr,
    input  logic [idp_pkg::DATA_W-1:0] pwdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [idp_pkg::DATA_W-1:0] s_pending_lines,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [idp_pkg::LINE_W-1:0] m_served_line,
    input  logic [1:0]                 m_action,
    input  logic [idp_pkg::DATA_W-1:0] m_line_count,
    input  logic [idp_pkg::DATA_W-1:0] m_spurious_total,
    input  logic [idp_pkg::DATA_W-1:0] m_masked_lines,
    input  logic                       m_last,
    output int                         fail_count,
    output int                         results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import idp_pkg::*;

    typedef struct {
        logic [LINE_W-1:0] line;
        action_t           act;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] spur_total;
        logic [DATA_W-1:0] masked;
        logic              last;
    } service_t;

    // Shadow of the block's registers and state.
    logic [DATA_W-1:0] enable_q;
    logic [DATA_W-1:0] handled_q;
    logic [LINE_W-1:0] tick_line_q;
    logic [DATA_W-1:0] line_counts [32];
    logic [DATA_W-1:0] spur_total_q;
    logic [DATA_W-1:0] disabled_q;

    service_t services_due [$];
    int       mismatches = 0;

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    function automatic void queue_service(logic [LINE_W-1:0] line, action_t act,
                                          logic [DATA_W-1:0] count);
        service_t s;
        s.line       = line;
        s.act        = act;
        s.count      = count;
        s.spur_total = spur_total_q;
        s.masked     = disabled_q;
        s.last       = 1'b0;
        services_due.push_back(s);
    endfunction

    function automatic void dispatch_pending(logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] pend;
        logic [LINE_W-1:0] tick;
        int                served;
        pend   = raw & enable_q & ~disabled_q;
        tick   = tick_line_q;
        served = 0;
        // The tick goes first and needs no handler.
        if (pend[tick]) begin
            line_counts[tick] = line_counts[tick] + 1;
            pend[tick] = 1'b0;
            queue_service(tick, ACT_TICK, line_counts[tick]);
            served++;
        end
        for (int n = 31; n >= 0; n--) begin
            if (pend[n]) begin
                if (handled_q[n]) begin
                    line_counts[n] = line_counts[n] + 1;
                    queue_service(LINE_W'(n), ACT_HANDLER, line_counts[n]);
                end else begin
                    spur_total_q  = spur_total_q + 1;
                    disabled_q[n] = 1'b1;
                    queue_service(LINE_W'(n), ACT_SPUR, line_counts[n]);
                end
                served++;
            end
        end
        if (served == 0)
            queue_service('0, ACT_NONE, '0);
        services_due[services_due.size()-1].last = 1'b1;
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: checker: %s", $time, what);
    endfunction

    always @(posedge aclk) begin
        service_t exp;
        if (!aresetn) begin
            enable_q     = '0;
            handled_q    = '0;
            tick_line_q  = TIMER_LINE_RESET;
            spur_total_q = '0;
            disabled_q   = '0;
            for (int i = 0; i < 32; i++)
                line_counts[i] = '0;
            services_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ENABLE:  enable_q    = pwdata;
                    REG_HANDLED: handled_q   = pwdata;
                    REG_TIMER:   tick_line_q = pwdata[LINE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                dispatch_pending(s_pending_lines);
            if (m_valid && m_ready) begin
                if (services_due.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing due: line %0d action %0d",
                                            m_served_line, m_action));
                end else begin
                    exp = services_due.pop_front();
                    if (m_served_line !== exp.line || m_action !== exp.act
                            || m_line_count !== exp.count
                            || m_spurious_total !== exp.spur_total
                            || m_masked_lines !== exp.masked || m_last !== exp.last)
                        flag_mismatch($sformatf({"expected line %0d act %0d count %0d ",
                            "spur %0d masked %h last %0b, got line %0d act %0d count %0d ",
                            "spur %0d masked %h last %0b"},
                            exp.line, exp.act, exp.count, exp.spur_total, exp.masked,
                            exp.last, m_served_line, m_action, m_line_count,
                            m_spurious_total, m_masked_lines, m_last));
                end
            end
        end
        fail_count  <= mismatches;
        results_due <= services_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the dispatcher testbench: clock, reset, register writes, input beats
// and the result-side ready pattern. Depends on idp_pkg, idp_checker and the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import idp_pkg::*;

    localparam logic [1:0] REG_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         HOLD_AT_BEAT = 150;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [ADDR_W-1:0] paddr           = '0;
    logic [DATA_W-1:0] pwdata          = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [DATA_W-1:0] s_pending_lines = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [LINE_W-1:0] m_served_line;
    logic [1:0]        m_action;
    logic [DATA_W-1:0] m_line_count;
    logic [DATA_W-1:0] m_spurious_total;
    logic [DATA_W-1:0] m_masked_lines;
    logic              m_last;
    int                fail_count;
    int                results_due;
    bit                no_idle = 1'b0;
    logic [LINE_W-1:0] tick_now = TIMER_LINE_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    interrupt_dispatch_priority DUT (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_pending_lines,
        .m_valid, .m_ready, .m_served_line, .m_action, .m_line_count,
        .m_spurious_total, .m_masked_lines, .m_last
    );

    idp_checker u_checker (
        .aclk, .aresetn, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_valid, .s_ready, .s_pending_lines,
        .m_valid, .m_ready, .m_served_line, .m_action, .m_line_count,
        .m_spurious_total, .m_masked_lines, .m_last,
        .fail_count, .results_due
    );

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pending(input logic [DATA_W-1:0] lines);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_pending_lines <= lines;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering beats and wait for every due result, so that the block is idle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TIMER)
            tick_now = value[LINE_W-1:0];
    endtask

    function automatic logic [DATA_W-1:0] random_pending();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return '0;
            1: return '1;
            2, 3, 4: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            5, 6: return (32'd1 << tick_now) | (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Result-side ready: random runs of high and low, and one long hold once the
    // block has produced enough beats, while the sender keeps offering items.
    initial begin
        int  run_left;
        int  beats;
        bit  held;
        run_left = 0;
        beats    = 0;
        held     = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                beats++;
            if (!held && beats >= HOLD_AT_BEAT) begin
                held     = 1'b1;
                run_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
                run_left = $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b0;
                run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                        : $urandom_range(9, 29);
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] enables;
        logic [DATA_W-1:0] handlers;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers at reset: nothing enabled, so every item reports nothing pending.
        send_pending('1);
        send_pending('0);
        wait_idle();

        write_reg(REG_ENABLE, '1);
        write_reg(REG_HANDLED, 32'hFFFF_FFF7);
        write_reg(REG_TIMER, 5'd15);
        send_pending(32'h0000_8000);
        send_pending(32'h8000_0001);
        send_pending(32'h0000_8008);
        send_pending(32'h0000_0008);
        send_pending('1);
        send_pending('0);
        wait_idle();

        // The tick moves onto a line already masked as spurious: it stays masked.
        write_reg(REG_TIMER, 5'd3);
        write_reg(REG_HANDLED, '1);
        send_pending(32'h0000_0008);
        send_pending(32'h0000_0009);
        wait_idle();

        write_reg(REG_TIMER, 5'd0);
        send_pending(32'h0000_0001);
        send_pending(32'h8000_0001);
        wait_idle();

        write_reg(REG_TIMER, 5'd31);
        write_reg(REG_ENABLE, 32'h0000_FFFF);
        send_pending(32'h8000_0000);
        send_pending('1);
        wait_idle();

        write_reg(REG_ENABLE, '1);
        write_reg(REG_UNUSED, $urandom);
        send_pending(32'h8000_0000);
        send_pending('1);
        send_pending(32'h5555_5555);
        send_pending(32'hAAAA_AAAA);
        wait_idle();

        for (int phase = 0; phase < 12; phase++) begin
            no_idle = (phase % 4 == 3);
            if (phase == 0)
                enables = '1;
            else if (phase == 5)
                enables = '0;
            else
                enables = $urandom | $urandom;
            handlers = '1;
            if (phase % 3 == 1)
                handlers[$urandom_range(0, 31)] = 1'b0;
            if (phase == 11)
                handlers = '0;
            write_reg(REG_ENABLE, enables);
            write_reg(REG_HANDLED, handlers);
            if (phase == 1)
                write_reg(REG_TIMER, 5'd0);
            else if (phase == 2)
                write_reg(REG_TIMER, 5'd31);
            else
                write_reg(REG_TIMER, $urandom_range(0, 31));
            for (int i = 0; i < 24; i++)
                send_pending(random_pending());
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
